// File: rtl/vector_direction_quantizer_macros.svh
// ----------------------------------------------------------------------------
// vector_direction_quantizer_macros.svh
// Assertion macros used by the checker file of the direction quantizer.
// ----------------------------------------------------------------------------
`ifndef VECTOR_DIRECTION_QUANTIZER_MACROS_SVH
`define VECTOR_DIRECTION_QUANTIZER_MACROS_SVH

// same-cycle implication, disabled in reset
`define VDQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define VDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/vdq_pkg.sv
// ----------------------------------------------------------------------------
// vdq_pkg
// Types, angle constants and the arctangent table of the direction quantizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vdq_pkg;

   // angles are Q9.8 degrees
   localparam int Z_BITS    = 17;
   localparam int ANG_BITS  = 17;
   localparam int ATAN_BITS = 14;
   localparam int ATAN_ENTRIES = 24;

   localparam logic [ANG_BITS-1:0] DEG_90    = 17'd23040;
   localparam logic [ANG_BITS-1:0] DEG_180   = 17'd46080;
   localparam logic [ANG_BITS-1:0] DEG_360   = 17'd92160;
   localparam logic [ANG_BITS-1:0] OFFS_22_5 = 17'd5760;
   localparam logic [ANG_BITS-1:0] OFFS_45   = 17'd11520;

   // floor(a / 45) and floor(a / 90) as (a * R) >> 16, exact for a < 512
   localparam int RECIP_SHIFT = 16;
   localparam logic [10:0] RECIP_45 = 11'd1457;
   localparam logic [9:0]  RECIP_90 = 10'd729;

   localparam logic [8:0] DEG_OFFSET = 9'd68;
   localparam logic [8:0] DEG_FULL   = 9'd360;

   localparam logic [8:0] CODE_UP       = 9'd0;
   localparam logic [8:0] CODE_UP_LEAN  = 9'd1;
   localparam logic [8:0] CODE_DOWN     = 9'd4;
   localparam logic [8:0] CODE_DOWN_LEAN = 9'd5;
   localparam logic [8:0] CODE_DOWN_DEG = 9'd180;

   // atan(2^-i) in Q9.8, rounded
   localparam logic [ATAN_BITS-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      14'd11520, 14'd6801, 14'd3593, 14'd1824, 14'd916, 14'd458, 14'd229, 14'd115,
      14'd57,    14'd29,   14'd14,   14'd7,    14'd4,   14'd2,   14'd1,   14'd0,
      14'd0,     14'd0,    14'd0,    14'd0,    14'd0,   14'd0,   14'd0,   14'd0
   };

   typedef enum logic [1:0] {
      MODE_FOUR    = 2'd0,
      MODE_EIGHT   = 2'd1,
      MODE_DEGREES = 2'd2,
      MODE_LEAN    = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type action;
      logic     dx_zero;
      logic     dx_neg;
      logic     dy_neg;
   } meta_type;

endpackage

// File: rtl/vdq_channels.sv
// ----------------------------------------------------------------------------
// vdq_req_if / vdq_rsp_if
// Valid/ready channels for point pairs and for heading results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vdq_req_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   action;
   logic signed [COORD_BITS-1:0] from_x;
   logic signed [COORD_BITS-1:0] from_y;
   logic signed [COORD_BITS-1:0] to_x;
   logic signed [COORD_BITS-1:0] to_y;

   modport source (output valid, action, from_x, from_y, to_x, to_y, input ready);
   modport sink   (input valid, action, from_x, from_y, to_x, to_y, output ready);
endinterface

interface vdq_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] heading;

   modport source (output valid, heading, input ready);
   modport sink   (input valid, heading, output ready);
endinterface

// File: rtl/vdq_prep.sv
// ----------------------------------------------------------------------------
// vdq_prep
// Forms dx, dy and their magnitudes; records the signs and the mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vdq_prep #(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [1:0]                     action,
   input  logic signed [COORD_BITS-1:0]   from_x,
   input  logic signed [COORD_BITS-1:0]   from_y,
   input  logic signed [COORD_BITS-1:0]   to_x,
   input  logic signed [COORD_BITS-1:0]   to_y,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic signed [COORD_BITS+2:0]   x_o,
   output logic signed [COORD_BITS+2:0]   y_o,
   output vdq_pkg::meta_type              meta_o
);
   import vdq_pkg::*;

   localparam int DW = COORD_BITS + 1;

   logic signed [DW-1:0]     dx;
   logic signed [DW-1:0]     dy;
   logic [DW-1:0]            ax;
   logic [DW-1:0]            ay;
   logic                     valid_ff;
   logic signed [DW+1:0]     x_ff, x_in;
   logic signed [DW+1:0]     y_ff, y_in;
   meta_type                 meta_ff, meta_in;

   always_comb begin
      dx = {to_x[COORD_BITS-1], to_x} - {from_x[COORD_BITS-1], from_x};
      dy = {to_y[COORD_BITS-1], to_y} - {from_y[COORD_BITS-1], from_y};
      // the most negative difference negates to itself, read unsigned it is right
      ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
      ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
      x_in = {2'b00, ax};
      y_in = {2'b00, ay};
      meta_in.action  = mode_type'(action);
      meta_in.dx_zero = (dx == '0);
      meta_in.dx_neg  = dx[DW-1];
      meta_in.dy_neg  = dy[DW-1];
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         meta_ff <= meta_in;
      end
   end

   assign out_valid = valid_ff;
   assign x_o       = x_ff;
   assign y_o       = y_ff;
   assign meta_o    = meta_ff;
endmodule

// File: rtl/vdq_cordic_stage.sv
// ----------------------------------------------------------------------------
// vdq_cordic_stage
// One registered vectoring micro-rotation: drive y toward zero, sum the angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vdq_cordic_stage #(
   parameter int COORD_BITS = 16,
   parameter int STAGE      = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [COORD_BITS+2:0]         x_i,
   input  logic signed [COORD_BITS+2:0]         y_i,
   input  logic signed [vdq_pkg::Z_BITS-1:0]    z_i,
   input  vdq_pkg::meta_type                    meta_i,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [COORD_BITS+2:0]         x_o,
   output logic signed [COORD_BITS+2:0]         y_o,
   output logic signed [vdq_pkg::Z_BITS-1:0]    z_o,
   output vdq_pkg::meta_type                    meta_o
);
   import vdq_pkg::*;

   localparam int XW = COORD_BITS + 3;
   localparam logic signed [Z_BITS-1:0] ANGLE =
      $signed({{(Z_BITS-ATAN_BITS){1'b0}}, ATAN_TABLE[STAGE]});

   logic signed [XW-1:0]     xs;
   logic signed [XW-1:0]     ys;
   logic                     valid_ff;
   logic signed [XW-1:0]     x_ff, x_in;
   logic signed [XW-1:0]     y_ff, y_in;
   logic signed [Z_BITS-1:0] z_ff, z_in;
   meta_type                 meta_ff;

   always_comb begin
      xs   = x_i >>> STAGE;
      ys   = y_i >>> STAGE;
      x_in = x_i;
      y_in = y_i;
      z_in = z_i;
      // a zero residual rotates nothing
      if (y_i > 0) begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + ANGLE;
      end else if (y_i < 0) begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - ANGLE;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         meta_ff <= meta_i;
      end
   end

   assign out_valid = valid_ff;
   assign x_o       = x_ff;
   assign y_o       = y_ff;
   assign z_o       = z_ff;
   assign meta_o    = meta_ff;
endmodule

// File: rtl/vdq_post.sv
// ----------------------------------------------------------------------------
// vdq_post
// Clamps the CORDIC angle to one quadrant and restores the full heading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vdq_post (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [vdq_pkg::Z_BITS-1:0]    z_i,
   input  vdq_pkg::meta_type                    meta_i,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [vdq_pkg::ANG_BITS-1:0]         d_o,
   output vdq_pkg::meta_type                    meta_o
);
   import vdq_pkg::*;

   logic [ANG_BITS-1:0] q;
   logic [ANG_BITS-1:0] d_raw;
   logic                valid_ff;
   logic [ANG_BITS-1:0] d_ff, d_in;
   meta_type            meta_ff;

   always_comb begin
      if (z_i[Z_BITS-1]) begin
         q = '0;
      end else if (ANG_BITS'(z_i) > DEG_90) begin
         q = DEG_90;
      end else begin
         q = ANG_BITS'(z_i);
      end
      if (!meta_i.dy_neg) begin
         d_raw = meta_i.dx_neg ? DEG_180 - q : q;
      end else begin
         d_raw = meta_i.dx_neg ? DEG_180 + q : DEG_360 - q;
      end
      // fold a full turn back to zero
      d_in = (d_raw >= DEG_360) ? d_raw - DEG_360 : d_raw;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         d_ff    <= d_in;
         meta_ff <= meta_i;
      end
   end

   assign out_valid = valid_ff;
   assign d_o       = d_ff;
   assign meta_o    = meta_ff;
endmodule

// File: rtl/vdq_quant.sv
// ----------------------------------------------------------------------------
// vdq_quant
// Maps the heading angle to the code of the selected mode; output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vdq_quant (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [vdq_pkg::ANG_BITS-1:0]   d_i,
   input  vdq_pkg::meta_type              meta_i,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [8:0]                     heading
);
   import vdq_pkg::*;

   logic [ANG_BITS-1:0] sum8;
   logic [ANG_BITS-1:0] sum4;
   logic [8:0]          a8;
   logic [8:0]          a4;
   logic [19:0]         p45;
   logic [18:0]         p90;
   logic [2:0]          octant;
   logic [1:0]          quad;
   logic [8:0]          deg_sum;
   logic [8:0]          deg;
   logic                valid_ff;
   logic [8:0]          heading_ff, heading_in;

   always_comb begin
      sum8    = d_i + OFFS_22_5;
      sum4    = d_i + OFFS_45;
      a8      = sum8[ANG_BITS-1:8];
      a4      = sum4[ANG_BITS-1:8];
      p45     = 20'(a8) * 20'(RECIP_45);
      p90     = 19'(a4) * 19'(RECIP_90);
      octant  = p45[RECIP_SHIFT+2:RECIP_SHIFT] + 3'd2;
      quad    = p90[RECIP_SHIFT+1:RECIP_SHIFT] + 2'd1;
      deg_sum = a8 + DEG_OFFSET;
      deg     = (deg_sum >= DEG_FULL) ? deg_sum - DEG_FULL : deg_sum;

      if (meta_i.dx_zero) begin
         // vertical or zero vector: fixed answers
         if (!meta_i.dy_neg) begin
            case (meta_i.action)
               MODE_DEGREES: heading_in = CODE_DOWN_DEG;
               MODE_LEAN:    heading_in = CODE_DOWN_LEAN;
               default:      heading_in = CODE_DOWN;
            endcase
         end else begin
            heading_in = (meta_i.action == MODE_LEAN) ? CODE_UP_LEAN : CODE_UP;
         end
      end else begin
         case (meta_i.action)
            MODE_EIGHT:   heading_in = {6'd0, octant};
            MODE_DEGREES: heading_in = deg;
            MODE_LEAN:    heading_in = {6'd0, quad, 1'b1};
            default:      heading_in = {6'd0, quad, 1'b0};
         endcase
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         heading_ff <= heading_in;
      end
   end

   assign out_valid = valid_ff;
   assign heading   = heading_ff;
endmodule

// File: rtl/vector_direction_quantizer.sv
// ----------------------------------------------------------------------------
// vector_direction_quantizer
// Heading of the vector between two screen points, quantized by mode.
//
//   channel   direction  payload                              transfer
//   req_chan  in         action, from_x, from_y, to_x, to_y   valid && ready
//   rsp_chan  out        heading                              valid && ready
//
// One item enters per cycle while rsp_chan does not stall; each result passes
// through one prep stage, one stage per CORDIC micro-rotation, one
// quadrant-restore stage and the output register.
// Every stage holds when the stage after it is full and stalled; bubbles
// collapse, so req_chan.ready stays high whenever the output register is empty.
// Reset clears the valid bits of all stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_direction_quantizer #(
   parameter int COORD_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic          clock,
   input  logic          reset,
   vdq_req_if.sink       req_chan,
   vdq_rsp_if.source     rsp_chan
);
   import vdq_pkg::*;

   localparam int XW = COORD_BITS + 3;

   logic                     valid_s [0:CORDIC_STAGES];
   logic                     ready_s [0:CORDIC_STAGES];
   logic signed [XW-1:0]     x_s     [0:CORDIC_STAGES];
   logic signed [XW-1:0]     y_s     [0:CORDIC_STAGES];
   logic signed [Z_BITS-1:0] z_s     [0:CORDIC_STAGES];
   meta_type                 meta_s  [0:CORDIC_STAGES];

   logic                     post_valid;
   logic                     post_ready;
   logic [ANG_BITS-1:0]      post_d;
   meta_type                 post_meta;

   vdq_prep #(
      .COORD_BITS (COORD_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .action    (req_chan.action),
      .from_x    (req_chan.from_x),
      .from_y    (req_chan.from_y),
      .to_x      (req_chan.to_x),
      .to_y      (req_chan.to_y),
      .out_valid (valid_s[0]),
      .out_ready (ready_s[0]),
      .x_o       (x_s[0]),
      .y_o       (y_s[0]),
      .meta_o    (meta_s[0])
   );

   // angle accumulator starts at zero
   assign z_s[0] = '0;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      vdq_cordic_stage #(
         .COORD_BITS (COORD_BITS),
         .STAGE      (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_s[i]),
         .in_ready  (ready_s[i]),
         .x_i       (x_s[i]),
         .y_i       (y_s[i]),
         .z_i       (z_s[i]),
         .meta_i    (meta_s[i]),
         .out_valid (valid_s[i+1]),
         .out_ready (ready_s[i+1]),
         .x_o       (x_s[i+1]),
         .y_o       (y_s[i+1]),
         .z_o       (z_s[i+1]),
         .meta_o    (meta_s[i+1])
      );
   end

   vdq_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_s[CORDIC_STAGES]),
      .in_ready  (ready_s[CORDIC_STAGES]),
      .z_i       (z_s[CORDIC_STAGES]),
      .meta_i    (meta_s[CORDIC_STAGES]),
      .out_valid (post_valid),
      .out_ready (post_ready),
      .d_o       (post_d),
      .meta_o    (post_meta)
   );

   vdq_quant u_quant (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (post_valid),
      .in_ready  (post_ready),
      .d_i       (post_d),
      .meta_i    (post_meta),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .heading   (rsp_chan.heading)
   );
endmodule

// File: rtl/vdq_checker.sv
// ----------------------------------------------------------------------------
// vdq_checker
// Port-level checks of the direction quantizer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "vector_direction_quantizer_macros.svh"

module vdq_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [8:0] rsp_heading
);
   localparam logic [8:0] HEADING_MAX = 9'd359;

   logic [7:0] pending_ff, pending_in;

   // items taken in and not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pending_in = pending_ff + 8'd1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pending_in = pending_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `VDQ_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "input stalled with empty output")
   `VDQ_ASSERT_NOW(a_heading_range, clock, reset, rsp_valid, rsp_heading <= HEADING_MAX, "heading out of range")
   `VDQ_ASSERT_NOW(a_no_invented_result, clock, reset, rsp_valid, pending_ff != 8'd0, "result without a pending item")
   `VDQ_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_heading), "stalled result changed")
endmodule

bind vector_direction_quantizer vdq_checker u_vdq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_heading (rsp_chan.heading)
);
